// ----- hdl/psda_pkg.sv -----
// ---------------------------------------------------------------------------
// PWM-synchronised dual-point sample averager: shared definitions
// Widths, register codes, reset values and the queue entry type.
// ---------------------------------------------------------------------------
package psda_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int SUM_BITS    = SAMPLE_BITS + 8;
   localparam int TICK_BITS   = 16;
   localparam int PER_BITS    = 8;

   localparam int REQ_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((1 + 2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_CNT_W   = $clog2(SUM_BITS);

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_TICKS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ON_TICKS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EARLY_TICK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LATE_TICK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PERIODS_AVG   = 3'd4;

   localparam logic [TICK_BITS-1:0] RST_PERIOD_TICKS  = 16'd20000;
   localparam logic [TICK_BITS-1:0] RST_ON_TICKS      = 16'd2000;
   localparam logic [TICK_BITS-1:0] RST_EARLY_TICK    = 16'd200;
   localparam logic [TICK_BITS-1:0] RST_LATE_TICK     = 16'd1399;
   localparam logic [PER_BITS-1:0]  RST_PERIODS_AVG   = 8'd10;

   typedef struct packed {
      logic                pwm;
      logic                avg_valid;
      logic [SUM_BITS-1:0] early_sum;
      logic [SUM_BITS-1:0] late_sum;
      logic [PER_BITS-1:0] divisor;
   } entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

endpackage

// ----- hdl/psda_front.sv -----
// ---------------------------------------------------------------------------
// Front end: configuration registers and tick classification
// Tracks the tick position, drives the PWM level, accumulates the two
// sample points and marks the tick on which an average is due.
// ---------------------------------------------------------------------------
module psda_front
   import psda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   tick_valid,
   input  logic [SAMPLE_BITS-1:0] tick_sample,
   input  logic                   queue_full,
   output logic                   tick_ready,
   output logic                   push,
   output entry_type              push_entry
);

   logic [TICK_BITS-1:0] period_ff, on_ff, early_tick_ff, late_tick_ff;
   logic [PER_BITS-1:0]  periods_ff;
   logic [TICK_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0]  early_sum_ff, early_sum_in;
   logic [SUM_BITS-1:0]  late_sum_ff, late_sum_in;
   logic [PER_BITS-1:0]  pcount_ff, pcount_in;

   logic [TICK_BITS-1:0] count_eff;
   logic [TICK_BITS:0]   count_next;
   logic [PER_BITS-1:0]  divisor;
   logic [PER_BITS-1:0]  pcount_inc;
   logic [SUM_BITS-1:0]  early_acc, late_acc;
   logic                 early_hit, late_hit, done;

   assign tick_ready = !queue_full;
   assign push       = tick_valid && tick_ready;

   always_comb begin
      count_eff  = (count_ff >= period_ff) ? '0 : count_ff;
      divisor    = (periods_ff == '0) ? PER_BITS'(1) : periods_ff;
      early_hit  = (count_eff == early_tick_ff);
      late_hit   = (count_eff == late_tick_ff);
      early_acc  = early_hit ? early_sum_ff + SUM_BITS'(tick_sample) : early_sum_ff;
      late_acc   = late_hit ? late_sum_ff + SUM_BITS'(tick_sample) : late_sum_ff;
      pcount_inc = late_hit ? pcount_ff + PER_BITS'(1) : pcount_ff;
      done       = late_hit && (pcount_inc >= divisor);
      count_next = {1'b0, count_eff} + (TICK_BITS + 1)'(1);

      push_entry.pwm       = (count_eff < on_ff);
      push_entry.avg_valid = done;
      push_entry.early_sum = early_acc;
      push_entry.late_sum  = late_acc;
      push_entry.divisor   = divisor;

      count_in     = count_ff;
      early_sum_in = early_sum_ff;
      late_sum_in  = late_sum_ff;
      pcount_in    = pcount_ff;
      if (push) begin
         count_in     = (count_next >= {1'b0, period_ff}) ? '0 : count_next[TICK_BITS-1:0];
         early_sum_in = done ? '0 : early_acc;
         late_sum_in  = done ? '0 : late_acc;
         pcount_in    = done ? '0 : pcount_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= RST_PERIOD_TICKS;
         on_ff         <= RST_ON_TICKS;
         early_tick_ff <= RST_EARLY_TICK;
         late_tick_ff  <= RST_LATE_TICK;
         periods_ff    <= RST_PERIODS_AVG;
         count_ff      <= '0;
         early_sum_ff  <= '0;
         late_sum_ff   <= '0;
         pcount_ff     <= '0;
      end else begin
         count_ff     <= count_in;
         early_sum_ff <= early_sum_in;
         late_sum_ff  <= late_sum_in;
         pcount_ff    <= pcount_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_PERIOD_TICKS: period_ff     <= csr_wdata;
               REG_ON_TICKS:     on_ff         <= csr_wdata;
               REG_EARLY_TICK:   early_tick_ff <= csr_wdata;
               REG_LATE_TICK:    late_tick_ff  <= csr_wdata;
               REG_PERIODS_AVG:  periods_ff    <= csr_wdata[PER_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- hdl/psda_queue.sv -----
// ---------------------------------------------------------------------------
// Classified-tick queue
// A short first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
module psda_queue
   import psda_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      head         = slot_ff[rptr_ff];
      status.count = count_ff;
      status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      wptr_in      = push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in      = pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in     = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/psda_back.sv -----
// ---------------------------------------------------------------------------
// Back end: averaging divider and result register
// Emits one result per classified tick and runs a bit-serial divider for
// the ticks that complete an average.
// ---------------------------------------------------------------------------
module psda_back
   import psda_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  entry_type              head,
   input  logic                   queue_empty,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_pwm,
   output logic                   rsp_avg_valid,
   output logic [SAMPLE_BITS-1:0] rsp_avg_early,
   output logic [SAMPLE_BITS-1:0] rsp_avg_late
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   tvalid_ff, tvalid_in;
   logic                   pwm_ff, pwm_in;
   logic                   avg_valid_ff, avg_valid_in;
   logic [SAMPLE_BITS-1:0] hold_early_ff, hold_early_in;
   logic [SAMPLE_BITS-1:0] hold_late_ff, hold_late_in;
   logic                   job_pwm_ff, job_pwm_in;
   logic [PER_BITS-1:0]    div_ff, div_in;
   logic [SUM_BITS-1:0]    quo_e_ff, quo_e_in, quo_l_ff, quo_l_in;
   logic [PER_BITS-1:0]    rem_e_ff, rem_e_in, rem_l_ff, rem_l_in;
   logic [DIV_CNT_W-1:0]   step_ff, step_in;

   logic                   out_free;
   logic [PER_BITS:0]      sh_e, sh_l;
   logic                   ge_e, ge_l;

   assign rsp_tvalid    = tvalid_ff;
   assign rsp_pwm       = pwm_ff;
   assign rsp_avg_valid = avg_valid_ff;
   assign rsp_avg_early = hold_early_ff;
   assign rsp_avg_late  = hold_late_ff;

   always_comb begin
      out_free = !tvalid_ff || rsp_tready;
      sh_e     = {rem_e_ff, quo_e_ff[SUM_BITS-1]};
      sh_l     = {rem_l_ff, quo_l_ff[SUM_BITS-1]};
      ge_e     = (sh_e >= {1'b0, div_ff});
      ge_l     = (sh_l >= {1'b0, div_ff});

      state_in      = state_ff;
      tvalid_in     = tvalid_ff && !rsp_tready;
      pwm_in        = pwm_ff;
      avg_valid_in  = avg_valid_ff;
      hold_early_in = hold_early_ff;
      hold_late_in  = hold_late_ff;
      job_pwm_in    = job_pwm_ff;
      div_in        = div_ff;
      quo_e_in      = quo_e_ff;
      quo_l_in      = quo_l_ff;
      rem_e_in      = rem_e_ff;
      rem_l_in      = rem_l_ff;
      step_in       = step_ff;
      pop           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty && out_free) begin
               pop = 1'b1;
               if (head.avg_valid) begin
                  job_pwm_in = head.pwm;
                  div_in     = head.divisor;
                  quo_e_in   = head.early_sum;
                  quo_l_in   = head.late_sum;
                  rem_e_in   = '0;
                  rem_l_in   = '0;
                  step_in    = '0;
                  state_in   = S_DIV;
               end else begin
                  tvalid_in    = 1'b1;
                  pwm_in       = head.pwm;
                  avg_valid_in = 1'b0;
               end
            end
         end
         S_DIV: begin
            rem_e_in = ge_e ? PER_BITS'(sh_e - {1'b0, div_ff}) : sh_e[PER_BITS-1:0];
            rem_l_in = ge_l ? PER_BITS'(sh_l - {1'b0, div_ff}) : sh_l[PER_BITS-1:0];
            quo_e_in = {quo_e_ff[SUM_BITS-2:0], ge_e};
            quo_l_in = {quo_l_ff[SUM_BITS-2:0], ge_l};
            step_in  = step_ff + DIV_CNT_W'(1);
            if (step_ff == DIV_CNT_W'(SUM_BITS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               tvalid_in     = 1'b1;
               pwm_in        = job_pwm_ff;
               avg_valid_in  = 1'b1;
               hold_early_in = quo_e_ff[SAMPLE_BITS-1:0];
               hold_late_in  = quo_l_ff[SAMPLE_BITS-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tvalid_ff     <= 1'b0;
         hold_early_ff <= '0;
         hold_late_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         tvalid_ff     <= tvalid_in;
         hold_early_ff <= hold_early_in;
         hold_late_ff  <= hold_late_in;
      end
   end

   always_ff @(posedge clock) begin
      pwm_ff       <= pwm_in;
      avg_valid_ff <= avg_valid_in;
      job_pwm_ff   <= job_pwm_in;
      div_ff       <= div_in;
      quo_e_ff     <= quo_e_in;
      quo_l_ff     <= quo_l_in;
      rem_e_ff     <= rem_e_in;
      rem_l_ff     <= rem_l_in;
      step_ff      <= step_in;
   end

endmodule

// ----- hdl/pwm_synced_dual_point_sample_averager.sv -----
// ---------------------------------------------------------------------------
// PWM-synchronised dual-point sample averager
// Every request item is one timer tick carrying a converter sample. The
// block drives the PWM level for that tick, accumulates samples at an
// early and a late point of each period and, after the programmed number
// of periods, returns the two averages. One response item per request.
//
// The csr_ port writes the five registers at any edge with csr_we high;
// the user must use it only while the block is idle, which the block does
// not enforce. A plain tick is accepted every cycle while the queue has
// space and reaches rsp_ through a queue slot and the response register.
// A tick that completes an average also passes the one-bit-per-cycle
// divider in the back end; a four-entry queue absorbs the following ticks,
// and req_tready drops only when that queue is full. When the receiver
// stalls, the response register holds and the queue fills, then req_tready
// falls. Synchronous reset restores the register defaults and clears the
// tick position, sums, period count, averages, queue and response valid.
// ---------------------------------------------------------------------------
module pwm_synced_dual_point_sample_averager
   import psda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // adc_sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pwm_out, avg_early, avg_late
   output logic                  rsp_tuser    // avg_valid
);

   logic                   push, pop;
   entry_type              push_entry, head;
   queue_status_type       qstat;
   logic                   rsp_pwm;
   logic [SAMPLE_BITS-1:0] rsp_avg_early, rsp_avg_late;

   psda_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .tick_valid  (req_tvalid),
      .tick_sample (req_tdata[SAMPLE_BITS-1:0]),
      .queue_full  (qstat.full),
      .tick_ready  (req_tready),
      .push        (push),
      .push_entry  (push_entry)
   );

   psda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstat)
   );

   psda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .queue_empty   (qstat.empty),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_pwm       (rsp_pwm),
      .rsp_avg_valid (rsp_tuser),
      .rsp_avg_early (rsp_avg_early),
      .rsp_avg_late  (rsp_avg_late)
   );

   assign rsp_tdata = {{(RSP_DATA_W - 1 - 2 * SAMPLE_BITS){1'b0}},
                       rsp_avg_late, rsp_avg_early, rsp_pwm};

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("item pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("item popped from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (qstat.count == $past(qstat.count) + QCNT_W'(1)))
      else $error("queue fill count out of step with pushes");

   a_ready_from_queue: assert property (@(posedge clock) disable iff (reset)
      req_tready == !qstat.full)
      else $error("request ready does not follow queue space");

endmodule

// ----- test/psda_output_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Response checker for the PWM-synchronised dual-point sample averager
// Watches the register port and both item channels. Every accepted request
// item is run through a local model of the tick counter, the two sample
// sums and the averaging, and the predicted response is queued. Every
// accepted response item is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
module psda_output_checker
   import psda_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // adc_sample
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // pwm_out, avg_early, avg_late
   input  logic                  rsp_tuser,   // avg_valid
   output int                    error_count,
   output int                    outstanding
);

   typedef struct packed {
      logic                   pwm;
      logic                   avg_valid;
      logic [SAMPLE_BITS-1:0] avg_early;
      logic [SAMPLE_BITS-1:0] avg_late;
   } tick_out_type;

   logic [TICK_BITS-1:0]   period_reg;
   logic [TICK_BITS-1:0]   on_reg;
   logic [TICK_BITS-1:0]   early_reg;
   logic [TICK_BITS-1:0]   late_reg;
   logic [PER_BITS-1:0]    avg_periods_reg;

   logic [TICK_BITS-1:0]   tick_pos;
   logic [SUM_BITS-1:0]    early_acc;
   logic [SUM_BITS-1:0]    late_acc;
   logic [PER_BITS-1:0]    periods_done;
   logic [SAMPLE_BITS-1:0] early_avg;
   logic [SAMPLE_BITS-1:0] late_avg;

   tick_out_type tick_outputs_q[$];

   // A count at or past the period is taken as count zero, and a zero
   // averaging count behaves as one.
   function automatic tick_out_type step_averager(input logic [SAMPLE_BITS-1:0] sample);
      logic [TICK_BITS:0]  pos;
      logic [PER_BITS-1:0] divisor;
      tick_out_type        result;
      pos = (tick_pos >= period_reg) ? '0 : {1'b0, tick_pos};
      divisor = (avg_periods_reg == '0) ? PER_BITS'(1) : avg_periods_reg;
      result.pwm = (pos < {1'b0, on_reg});
      result.avg_valid = 1'b0;
      if (pos == {1'b0, early_reg}) early_acc = early_acc + SUM_BITS'(sample);
      if (pos == {1'b0, late_reg}) begin
         late_acc = late_acc + SUM_BITS'(sample);
         periods_done = periods_done + PER_BITS'(1);
         if (periods_done >= divisor) begin
            early_avg = SAMPLE_BITS'(early_acc / divisor);
            late_avg = SAMPLE_BITS'(late_acc / divisor);
            early_acc = '0;
            late_acc = '0;
            periods_done = '0;
            result.avg_valid = 1'b1;
         end
      end
      pos = pos + (TICK_BITS + 1)'(1);
      if (pos >= {1'b0, period_reg}) pos = '0;
      tick_pos = pos[TICK_BITS-1:0];
      result.avg_early = early_avg;
      result.avg_late = late_avg;
      return result;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count = error_count + 1;
      end
   endfunction

   always @(posedge clock) begin : monitor
      tick_out_type want;
      if (reset) begin
         period_reg = RST_PERIOD_TICKS;
         on_reg = RST_ON_TICKS;
         early_reg = RST_EARLY_TICK;
         late_reg = RST_LATE_TICK;
         avg_periods_reg = RST_PERIODS_AVG;
         tick_pos = '0;
         early_acc = '0;
         late_acc = '0;
         periods_done = '0;
         early_avg = '0;
         late_avg = '0;
         tick_outputs_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tick_outputs_q.size() == 0) begin
               $display("%0t ns: response item with none expected, got %h / %b",
                        $time, rsp_tdata, rsp_tuser);
               error_count = error_count + 1;
            end else begin
               want = tick_outputs_q.pop_front();
               check_field("pwm_out", 32'(want.pwm), 32'(rsp_tdata[0]));
               check_field("avg_valid", 32'(want.avg_valid), 32'(rsp_tuser));
               check_field("avg_early", 32'(want.avg_early),
                           32'(rsp_tdata[SAMPLE_BITS:1]));
               check_field("avg_late", 32'(want.avg_late),
                           32'(rsp_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1]));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_PERIOD_TICKS: period_reg = csr_wdata;
               REG_ON_TICKS:     on_reg = csr_wdata;
               REG_EARLY_TICK:   early_reg = csr_wdata;
               REG_LATE_TICK:    late_reg = csr_wdata;
               REG_PERIODS_AVG:  avg_periods_reg = csr_wdata[PER_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            tick_outputs_q.push_back(step_averager(req_tdata[SAMPLE_BITS-1:0]));
      end
      outstanding = tick_outputs_q.size();
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench top for the PWM-synchronised dual-point sample averager
// Drives timer tick items with converter samples through a sequence of
// register settings: a short directed part for the corner cases, then
// random settings and samples with random idling on both channels and one
// long receiver hold-off. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_top
   import psda_pkg::*;
();

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_TICKS = 2000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // adc_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // pwm_out, avg_early, avg_late
   logic                  rsp_tuser;   // avg_valid

   int error_count;
   int outstanding;
   int cycle_count;
   bit hold_off_req;
   bit hold_started;
   bit rsp_gaps_on;

   pwm_synced_dual_point_sample_averager DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   psda_output_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
      endcase
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver: ready bursts of random length, short or occasionally long
   // stalls, and one long hold-off when the stimulus asks for it.
   initial begin
      int unsigned burst;
      int unsigned gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !hold_started) begin
            hold_started = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            burst = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
            repeat (burst) @(posedge clock);
            gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                               : $urandom_range(15, 60);
            if (rsp_gaps_on) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   task automatic send_tick(input logic [SAMPLE_BITS-1:0] sample, input bit gaps_on);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(sample);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned period, input int unsigned on,
                            input int unsigned early, input int unsigned late,
                            input int unsigned navg);
      write_reg(REG_PERIOD_TICKS, period);
      write_reg(REG_ON_TICKS, on);
      write_reg(REG_EARLY_TICK, early);
      write_reg(REG_LATE_TICK, late);
      write_reg(REG_PERIODS_AVG, navg & 8'hFF);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SUM_BITS + 4) @(posedge clock);
   endtask

   // Directed phases cycle through the sample extremes and alternating bits.
   task automatic run_phase(input int unsigned ticks, input bit directed, input bit gaps_on);
      logic [SAMPLE_BITS-1:0] patterns [4];
      patterns[0] = '0;
      patterns[1] = '1;
      patterns[2] = SAMPLE_BITS'(10'h155);
      patterns[3] = SAMPLE_BITS'(10'h2AA);
      for (int unsigned i = 0; i < ticks; i++)
         send_tick(directed ? patterns[2'(i)] : pick_sample(), gaps_on);
      req_tvalid <= 1'b0;
      wait_idle();
   endtask

   initial begin
      int unsigned random_ticks;
      int unsigned period;
      int unsigned on;
      int unsigned early;
      int unsigned late;
      int unsigned navg;
      int unsigned ticks;
      int unsigned span;
      bit          first_random;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      hold_off_req = 1'b0;
      rsp_gaps_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: the drive is on and no sample point is reached.
      run_phase(4, 1'b1, 1'b0);
      // Short period, drive never on, an average every period.
      configure(4, 0, 1, 3, 1);
      run_phase(5, 1'b1, 1'b1);
      // Both sample points equal, zero averaging count, drive always on.
      configure(3, 65535, 2, 2, 0);
      run_phase(3, 1'b1, 1'b1);
      // Period and averaging count lowered in the middle of a run.
      configure(6, 3, 0, 1, 3);
      run_phase(9, 1'b1, 1'b1);
      configure(2, 1, 0, 1, 1);
      run_phase(3, 1'b1, 1'b0);
      // Zero period keeps the count at zero.
      configure(0, 1, 0, 0, 2);
      run_phase(3, 1'b1, 1'b1);
      // Early sample point beyond the period never fires.
      configure(5, 5, 7, 3, 2);
      run_phase(10, 1'b1, 1'b1);

      random_ticks = 0;
      configure(65535, 65535, 0, 1, 255);
      run_phase(150, 1'b0, 1'b1);
      random_ticks += 150;
      configure(2, 1, 1, 0, 255);
      run_phase(520, 1'b0, 1'b1);
      random_ticks += 520;

      first_random = 1'b1;
      while (random_ticks < RANDOM_TICKS) begin
         case ($urandom_range(0, 19))
            0: period = 0;
            1: period = 1;
            2, 3: period = $urandom_range(25, 200);
            default: period = $urandom_range(2, 24);
         endcase
         span = (period == 0) ? 1 : period;
         case ($urandom_range(0, 9))
            0: on = 0;
            1: on = 65535;
            default: on = $urandom_range(0, span + 1);
         endcase
         case ($urandom_range(0, 7))
            0: early = (($urandom_range(0, 1) == 0) ? 65535 : $urandom_range(span, span + 3));
            default: early = $urandom_range(0, span - 1);
         endcase
         case ($urandom_range(0, 7))
            0: late = early;
            1: late = $urandom_range(span, span + 3);
            default: late = $urandom_range(0, span - 1);
         endcase
         case ($urandom_range(0, 19))
            0, 1: navg = 0;
            2: navg = $urandom_range(7, 40);
            default: navg = $urandom_range(1, 6);
         endcase
         ticks = span * ((navg == 0) ? 1 : navg) * $urandom_range(1, 3);
         if (ticks < 40) ticks = 40;
         if (ticks > 400) ticks = 400;
         rsp_gaps_on = ($urandom_range(0, 4) != 0);
         configure(period, on, early, late, navg);
         if (first_random) begin
            // The receiver holds off while the first part of this phase is offered.
            hold_off_req = 1'b1;
            wait (hold_started);
            run_phase(ticks, 1'b0, 1'b0);
            first_random = 1'b0;
         end else begin
            run_phase(ticks, 1'b0, $urandom_range(0, 4) != 0);
         end
         random_ticks += ticks;
      end

      wait_idle();
      if (error_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
